/* rtl/fmsrd_pkg.sv */
// Types and constants shared by the FM station run detector.
// Word layouts, register map codes and run limits. No dependencies.
`default_nettype none

package fmsrd_pkg;

  localparam int unsigned FreqBits  = 22;
  localparam int unsigned LevelBits = 16;
  localparam int unsigned LenBits   = 3;
  localparam int unsigned RunMax    = 5;
  localparam int unsigned RunKeep   = 3;
  localparam int unsigned AddrBits  = 4;
  localparam int unsigned DataBits  = 32;

  // Register indexes (byte address = 4 * index)
  localparam logic [1:0] RegThreshold = 2'd0;
  localparam logic [1:0] RegBandLow   = 2'd1;
  localparam logic [1:0] RegBandHigh  = 2'd2;

  localparam logic [LevelBits-1:0] ThresholdReset = 16'd16384;
  localparam logic [FreqBits-1:0]  BandLowReset   = 22'd1392;
  localparam logic [FreqBits-1:0]  BandHighReset  = 22'd1728;

  typedef struct packed {
    logic [FreqBits-1:0]  sample_freq;
    logic [LevelBits-1:0] signal_level;
  } in_word_t;

  typedef struct packed {
    logic [FreqBits:0]    center_freq_x2;
    logic [LevelBits-1:0] station_strength;
    logic [LenBits-1:0]   run_length;
  } out_word_t;

  typedef struct packed {
    logic [LevelBits-1:0] strong_threshold;
    logic [FreqBits-1:0]  band_low_excl;
    logic [FreqBits-1:0]  band_high_excl;
  } cfg_t;

endpackage

`default_nettype wire

/* rtl/fmsrd_run.sv */
// Run tracker: counts strong samples, keeps the first three, picks the point.
// Depends on fmsrd_pkg.
`default_nettype none

module fmsrd_run
  import fmsrd_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      adv_i,
  input  wire in_word_t  word_i,
  input  wire cfg_t      cfg_i,
  output logic           hit_o,
  output out_word_t      res_o
);

  logic [LenBits-1:0]   count_q, count_d;
  logic [FreqBits-1:0]  freq_q  [RunKeep];
  logic [LevelBits-1:0] level_q [RunKeep];

  logic                 level_strong;
  logic                 in_band;
  logic [FreqBits:0]    fx2;
  logic [LevelBits:0]   lsum;
  logic [LevelBits-1:0] str;

  assign level_strong = word_i.signal_level > cfg_i.strong_threshold;

  always_comb begin
    fx2  = '0;
    lsum = '0;
    str  = '0;
    unique case (count_q)
      3'd1: begin
        fx2 = {freq_q[0], 1'b0};
        str = level_q[0];
      end
      3'd2: begin
        fx2  = {1'b0, freq_q[0]} + {1'b0, freq_q[1]};
        lsum = {1'b0, level_q[0]} + {1'b0, level_q[1]};
        str  = lsum[LevelBits:1];
      end
      3'd3: begin
        fx2 = {freq_q[1], 1'b0};
        str = level_q[1];
      end
      3'd4: begin
        fx2  = {1'b0, freq_q[1]} + {1'b0, freq_q[2]};
        lsum = {1'b0, level_q[1]} + {1'b0, level_q[2]};
        str  = lsum[LevelBits:1];
      end
      default: begin
        fx2 = {freq_q[2], 1'b0};
        str = level_q[2];
      end
    endcase
  end

  assign in_band = (fx2 > {cfg_i.band_low_excl, 1'b0}) &&
                   (fx2 < {cfg_i.band_high_excl, 1'b0});
  assign hit_o   = !level_strong && (count_q != '0) && in_band;

  assign res_o.center_freq_x2   = fx2;
  assign res_o.station_strength = str;
  assign res_o.run_length       = count_q;

  always_comb begin
    count_d = count_q;
    if (level_strong) begin
      if (count_q < LenBits'(RunMax)) count_d = count_q + LenBits'(1);
    end else begin
      count_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (adv_i) begin
      count_q <= count_d;
    end
  end

  // keep only the first samples of a run
  always_ff @(posedge clk_i) begin
    if (adv_i && level_strong && (count_q < LenBits'(RunKeep))) begin
      freq_q[count_q[1:0]]  <= word_i.sample_freq;
      level_q[count_q[1:0]] <= word_i.signal_level;
    end
  end

endmodule

`default_nettype wire

/* rtl/fm_station_run_detector.sv */
// FM station run detector top level: handshakes, register file, result word.
// Depends on fmsrd_pkg and fmsrd_run.
//
//   channel   direction  handshake               word
//   in        sink       in_valid_i/in_stall_o   in_word_i  (in_word_t)
//   out       source     out_valid_o/out_stall_i out_word_o (out_word_t)
//   config    APB slave  psel/penable/pready     paddr, pwdata, prdata
//
// A word accepted into the input register passes the run update and point
// selection and, on a hit, is loaded into the result register. One word is
// accepted per cycle while the output is not stalled. Reset clears the run
// count, both valid flags and the registers to their defaults. A stall on the
// output holds the result word and, once the input register is full, stalls
// the input.
`default_nettype none

module fm_station_run_detector
  import fmsrd_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // sample words
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire in_word_t            in_word_i,
  // station words
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output out_word_t                out_word_o,
  // configuration
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [AddrBits-1:0] paddr,
  input  wire logic [DataBits-1:0] pwdata,
  output logic [DataBits-1:0]      prdata,
  output logic                     pready
);

  cfg_t      cfg_q;
  logic      a_valid_q;
  in_word_t  a_word_q;
  logic      out_valid_q;
  out_word_t out_q;

  logic      out_free;
  logic      a_go;
  logic      in_take;
  logic      hit;
  out_word_t res;
  logic      cfg_wr;

  // ---------------------------------------------------------------------------
  // Register file
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.strong_threshold <= ThresholdReset;
      cfg_q.band_low_excl    <= BandLowReset;
      cfg_q.band_high_excl   <= BandHighReset;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        RegThreshold: cfg_q.strong_threshold <= pwdata[LevelBits-1:0];
        RegBandLow:   cfg_q.band_low_excl    <= pwdata[FreqBits-1:0];
        RegBandHigh:  cfg_q.band_high_excl   <= pwdata[FreqBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      RegThreshold: prdata = DataBits'(cfg_q.strong_threshold);
      RegBandLow:   prdata = DataBits'(cfg_q.band_low_excl);
      RegBandHigh:  prdata = DataBits'(cfg_q.band_high_excl);
      default:      prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Flow control: advance the input register whenever the result register
  // can take a word, so a held result never blocks more than one sample.
  // ---------------------------------------------------------------------------
  assign out_free   = !out_valid_q || !out_stall_i;
  assign a_go       = a_valid_q && out_free;
  assign in_stall_o = a_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_take) begin
      a_valid_q <= 1'b1;
    end else if (a_go) begin
      a_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) a_word_q <= in_word_i;
  end

  // ---------------------------------------------------------------------------
  // Run tracking and point selection
  // ---------------------------------------------------------------------------
  fmsrd_run u_run (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (a_go),
    .word_i (a_word_q),
    .cfg_i  (cfg_q),
    .hit_o  (hit),
    .res_o  (res)
  );

  // ---------------------------------------------------------------------------
  // Result register: load on a hit, drop once taken downstream
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= a_go && hit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_go && hit) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

`ifndef ASSERT_OFF
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.run_length != '0) && (out_q.run_length <= LenBits'(RunMax)))
    else $error("result word with run length out of range");

  a_stall_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> a_valid_q && out_valid_q)
    else $error("input stalled with nothing held");

  a_blocked_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_valid_q && out_valid_q && out_stall_i) |-> in_stall_o)
    else $error("input taken while result register is blocked");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(a_valid_q))
    else $error("result word appeared without a sample in flight");
`endif

endmodule

`default_nettype wire
